@@ rtl/line_pixel_stepper_core_defines.svh @@
// ----------------------------------------------------------------------------
// line_pixel_stepper_core_defines
// Assertion macros for the line pixel stepper; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_STEPPER_CORE_DEFINES_SVH
`define LINE_PIXEL_STEPPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LPS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("line pixel stepper assertion failed");
`define LPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("line pixel stepper assertion failed");
`else
`define LPS_ASSERT(lbl, clk, rstn, prop)
`define LPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// lps_pkg
// Types and constants shared by the line pixel stepper modules.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int COORD_BITS  = 10;
    localparam int SPAN_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int TWICE_BITS  = COORD_BITS + 3;
    localparam int FIELD_BITS  = 10;
    localparam int COLOUR_BITS = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } lps_cmd_t;

    typedef enum logic [0:0] {
        LPS_IDLE = 1'b0,
        LPS_DRAW = 1'b1
    } lps_state_t;

    typedef struct packed {
        lps_cmd_t                command;
        logic [FIELD_BITS-1:0]   start_x;
        logic [FIELD_BITS-1:0]   start_y;
        logic [FIELD_BITS-1:0]   end_x;
        logic [FIELD_BITS-1:0]   end_y;
        logic [COLOUR_BITS-1:0]  line_colour;
    } lps_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0]   pixel_x;
        logic [FIELD_BITS-1:0]   pixel_y;
        logic [COLOUR_BITS-1:0]  pixel_colour;
        logic                    final_pixel;
    } lps_out_t;

    // decoded request passed from front to back
    typedef struct packed {
        lps_cmd_t                  command;
        logic [COORD_BITS-1:0]     cursor_x;
        logic [COORD_BITS-1:0]     cursor_y;
        logic [COORD_BITS-1:0]     target_x;
        logic [COORD_BITS-1:0]     target_y;
        logic [SPAN_BITS-1:0]      span_x;
        logic signed [SPAN_BITS-1:0] neg_span_y;
        logic                      step_left;
        logic                      step_up;
        logic signed [ERR_BITS-1:0] error_term;
        logic [COLOUR_BITS-1:0]    colour;
    } lps_op_t;

endpackage

@@ rtl/line_pixel_stepper_core.sv @@
// ----------------------------------------------------------------------------
// line_pixel_stepper_core
// All-octant Bresenham line generator: start requests set up a line, step
// requests emit one pixel each until the end point.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue has room. A start request
// gives no pixel; a step request on an active line gives one pixel, passed
// through the queue stage, then the pixel output register. The error-term
// update in the back end does one Bresenham step per clock, which sets the
// pixel rate at one per clock while m_ready stays high.
module line_pixel_stepper_core
    import lps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lps_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lps_out_t m_data
);

    logic    push_valid;
    logic    push_ready;
    lps_op_t push_op;
    lps_op_t q_op;
    logic    q_valid;
    logic    q_pop;

    lps_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    lps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_op    (push_op),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_op    (q_op)
    );

    lps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (q_valid),
        .op_pop   (q_pop),
        .op       (q_op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ rtl/lps_front.sv @@
// ----------------------------------------------------------------------------
// lps_front
// Accepts requests, classifies them and computes the line setup terms.
// ----------------------------------------------------------------------------
module lps_front
    import lps_pkg::*;
(
    input  logic    s_valid,
    output logic    s_ready,
    input  lps_in_t s_data,
    output logic    push_valid,
    input  logic    push_ready,
    output lps_op_t push_op
);

    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [COORD_BITS-1:0] abs_dx, abs_dy;
    logic [SPAN_BITS-1:0]  span_x;
    logic signed [SPAN_BITS-1:0] neg_span_y;

    assign x0 = COORD_BITS'(s_data.start_x);
    assign y0 = COORD_BITS'(s_data.start_y);
    assign x1 = COORD_BITS'(s_data.end_x);
    assign y1 = COORD_BITS'(s_data.end_y);

    assign abs_dx     = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    assign abs_dy     = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    assign span_x     = {1'b0, abs_dx};
    assign neg_span_y = -$signed({1'b0, abs_dy});

    always_comb begin
        push_op            = '0;
        push_op.command    = s_data.command;
        push_op.cursor_x   = x0;
        push_op.cursor_y   = y0;
        push_op.target_x   = x1;
        push_op.target_y   = y1;
        push_op.span_x     = span_x;
        push_op.neg_span_y = neg_span_y;
        push_op.step_left  = !(x0 < x1);
        push_op.step_up    = !(y0 < y1);
        push_op.error_term = $signed({1'b0, span_x}) + $signed({neg_span_y[SPAN_BITS-1],
                                                              neg_span_y});
        push_op.colour     = s_data.line_colour;
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

@@ rtl/lps_queue.sv @@
// ----------------------------------------------------------------------------
// lps_queue
// Short request queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`include "line_pixel_stepper_core_defines.svh"

module lps_queue
    import lps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  lps_op_t wr_op,
    output logic    rd_valid,
    input  logic    rd_pop,
    output lps_op_t rd_op
);

    lps_op_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  push, pop;

    assign wr_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_op    = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

    `LPS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_BITS'(QUEUE_DEPTH))
    `LPS_ASSERT_ALWAYS(a_reset_empty, aclk, (!aresetn) |=> (count_reg == '0))

endmodule

@@ rtl/lps_back.sv @@
// ----------------------------------------------------------------------------
// lps_back
// Line state and Bresenham stepping; one request per clock into a pixel
// output register, while that register is empty or m_ready is high.
// ----------------------------------------------------------------------------
`include "line_pixel_stepper_core_defines.svh"

module lps_back
    import lps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     op_valid,
    output logic     op_pop,
    input  lps_op_t  op,
    output logic     m_valid,
    input  logic     m_ready,
    output lps_out_t m_data
);

    lps_state_t                  state_reg, state_next;
    logic [COORD_BITS-1:0]       cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0]       cursor_y_reg, cursor_y_next;
    logic [COORD_BITS-1:0]       target_x_reg, target_x_next;
    logic [COORD_BITS-1:0]       target_y_reg, target_y_next;
    logic [SPAN_BITS-1:0]        span_x_reg, span_x_next;
    logic signed [SPAN_BITS-1:0] neg_span_y_reg, neg_span_y_next;
    logic                        step_left_reg, step_left_next;
    logic                        step_up_reg, step_up_next;
    logic signed [ERR_BITS-1:0]  error_reg, error_next;
    logic [COLOUR_BITS-1:0]      colour_reg, colour_next;
    logic                        m_valid_reg, m_valid_next;
    lps_out_t                    m_data_reg, m_data_next;

    logic                         pop, emit, last, move_x, move_y;
    logic signed [TWICE_BITS-1:0] twice, span_ext, neg_ext, err_ext, err_sum;

    assign pop    = op_valid && (!m_valid_reg || m_ready);
    assign op_pop = pop;
    assign last   = (cursor_x_reg == target_x_reg) && (cursor_y_reg == target_y_reg);

    assign twice    = $signed({error_reg, 1'b0});
    assign span_ext = $signed({2'b00, span_x_reg});
    assign neg_ext  = $signed({{2{neg_span_y_reg[SPAN_BITS-1]}}, neg_span_y_reg});
    assign err_ext  = $signed({error_reg[ERR_BITS-1], error_reg});
    assign move_x   = (twice >= neg_ext);
    assign move_y   = (twice <= span_ext);
    assign err_sum  = err_ext + (move_x ? neg_ext : '0) + (move_y ? span_ext : '0);

    // next state
    always_comb begin
        state_next = state_reg;
        if (pop) begin
            unique case (op.command)
                CMD_START: state_next = LPS_DRAW;
                CMD_STEP: begin
                    if (state_reg == LPS_DRAW && last) begin
                        state_next = LPS_IDLE;
                    end
                end
            endcase
        end
    end

    // outputs and datapath
    always_comb begin
        emit            = 1'b0;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        span_x_next     = span_x_reg;
        neg_span_y_next = neg_span_y_reg;
        step_left_next  = step_left_reg;
        step_up_next    = step_up_reg;
        error_next      = error_reg;
        colour_next     = colour_reg;

        unique case (state_reg)
            LPS_IDLE: emit = 1'b0;
            LPS_DRAW: emit = pop && (op.command == CMD_STEP);
        endcase

        if (pop && op.command == CMD_START) begin
            cursor_x_next   = op.cursor_x;
            cursor_y_next   = op.cursor_y;
            target_x_next   = op.target_x;
            target_y_next   = op.target_y;
            span_x_next     = op.span_x;
            neg_span_y_next = op.neg_span_y;
            step_left_next  = op.step_left;
            step_up_next    = op.step_up;
            error_next      = op.error_term;
            colour_next     = op.colour;
        end else if (emit && !last) begin
            error_next = err_sum[ERR_BITS-1:0];
            if (move_x) begin
                cursor_x_next = step_left_reg ? cursor_x_reg - 1'b1 : cursor_x_reg + 1'b1;
            end
            if (move_y) begin
                cursor_y_next = step_up_reg ? cursor_y_reg - 1'b1 : cursor_y_reg + 1'b1;
            end
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next             = 1'b1;
            m_data_next.pixel_x      = FIELD_BITS'(cursor_x_reg);
            m_data_next.pixel_y      = FIELD_BITS'(cursor_y_reg);
            m_data_next.pixel_colour = colour_reg;
            m_data_next.final_pixel  = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= LPS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cursor_x_reg   <= cursor_x_next;
        cursor_y_reg   <= cursor_y_next;
        target_x_reg   <= target_x_next;
        target_y_reg   <= target_y_next;
        span_x_reg     <= span_x_next;
        neg_span_y_reg <= neg_span_y_next;
        step_left_reg  <= step_left_next;
        step_up_reg    <= step_up_next;
        error_reg      <= error_next;
        colour_reg     <= colour_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LPS_ASSERT(a_final_goes_idle, aclk, aresetn, (emit && last) |=> (state_reg == LPS_IDLE))
    `LPS_ASSERT(a_emit_shows_pixel, aclk, aresetn, emit |=> m_valid_reg)

endmodule
